/* rtl/core/teq_pkg.sv */
`default_nettype none

package teq_pkg;

  // default queue depth and the cap on events fired per input beat
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned MAX_FIRE  = 16;
  localparam int unsigned FIRE_W    = 5;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    K_SET_OK   = 3'd0,
    K_FULL     = 3'd1,
    K_BAD_IVL  = 3'd2,
    K_CLEARED  = 3'd3,
    K_NO_HND   = 3'd4,
    K_TICK     = 3'd5,
    K_FIRED    = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET,
    ST_SET_WR,
    ST_CLR,
    ST_FIRE
  } state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_FROM_PREV,
    OP_FROM_NEXT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } ctl_t;

  typedef struct packed {
    logic ge;     // empty, or deadline not earlier than key
    logic due;    // valid and deadline at or before key
    logic match;  // valid and slot equals handle
  } flags_t;

  typedef struct packed {
    logic               valid;
    logic        [31:0] deadline;
    logic        [7:0]  action;
    logic signed [31:0] argument;
  } ent_t;

endpackage

`default_nettype wire

/* rtl/core/teq_cell.sv */
`default_nettype none

// One queue position. Holds an entry and moves it to/from its neighbors.
module teq_cell #(
  parameter int unsigned SLOT_W = 4,
  parameter int unsigned HND_W  = 4
) (
  input  wire                clk,
  input  wire                rst_n,
  input  teq_pkg::ctl_t      ctl_i,
  input  wire  [31:0]        key_i,
  input  wire  [HND_W-1:0]   hnd_i,
  input  teq_pkg::ent_t      new_ent_i,
  input  wire  [SLOT_W-1:0]  new_slot_i,
  input  teq_pkg::ent_t      prev_ent_i,
  input  wire  [SLOT_W-1:0]  prev_slot_i,
  input  teq_pkg::ent_t      next_ent_i,
  input  wire  [SLOT_W-1:0]  next_slot_i,
  output teq_pkg::ent_t      ent_o,
  output logic [SLOT_W-1:0]  slot_o,
  output teq_pkg::flags_t    flags_o
);

  teq_pkg::ent_t     ent_r;
  teq_pkg::ent_t     ent_nxt;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic [31:0]       diff;

  always_comb begin
    unique case (ctl_i.op)
      teq_pkg::OP_HOLD: begin
        ent_nxt  = ent_r;
        slot_nxt = slot_r;
      end
      teq_pkg::OP_LOAD: begin
        ent_nxt  = new_ent_i;
        slot_nxt = new_slot_i;
      end
      teq_pkg::OP_FROM_PREV: begin
        ent_nxt  = prev_ent_i;
        slot_nxt = prev_slot_i;
      end
      teq_pkg::OP_FROM_NEXT: begin
        ent_nxt  = next_ent_i;
        slot_nxt = next_slot_i;
      end
      default: begin
        ent_nxt  = ent_r;
        slot_nxt = slot_r;
      end
    endcase
  end

  // only the valid bit is reset; payload is ignored while invalid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.deadline <= ent_nxt.deadline;
    ent_r.action   <= ent_nxt.action;
    ent_r.argument <= ent_nxt.argument;
    slot_r         <= slot_nxt;
  end

  // wrap-safe compare: sign of deadline - key
  assign diff = ent_r.deadline - key_i;

  assign flags_o.ge    = !ent_r.valid || !diff[31];
  assign flags_o.due   = ent_r.valid && ((diff == 32'd0) || diff[31]);
  assign flags_o.match = ent_r.valid && (HND_W'(slot_r) == hnd_i);

  assign ent_o  = ent_r;
  assign slot_o = slot_r;

endmodule

`default_nettype wire

/* rtl/core/timed_event_queue.sv */
`default_nettype none

// Timed event queue. A row of DEPTH cells holds the pending events sorted by
// deadline, earliest in cell 0, next to a 32-bit time counter. Input beats
// carry a command on in_tuser: set schedules an event at now + interval and
// answers with its slot handle (or full / bad interval), clear drops a handle,
// tick advances time by elapsed. Clear and tick then emit one fired beat per
// due event, in deadline order and at most 16 per command, followed by a
// status beat with tlast set; set always answers with one beat. Equal
// deadlines fire newest first, and deadlines compare by the sign of the
// 32-bit difference, so time may wrap. Command 3 is dropped with no answer.
// Sequence with a free output: set passes through accept, cell compare and
// insert shift; tick goes from accept to the fire loop, and clear adds a
// removal step in between, the fire loop ending with the status beat. Cell 0
// checks its deadline and the whole row shifts left in the same cycle as each
// fired beat. Output backpressure stalls the sequence while the output
// register is full. The next beat is taken as soon as the block is idle
// again, even while the last answer waits in the output register.
module timed_event_queue #(
  parameter int unsigned DEPTH = teq_pkg::DEPTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // tdata: interval[30:0], action[38:31], argument[70:39], handle[74:71],
  //        elapsed[90:75], zero pad
  input  wire  [teq_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: command[1:0]
  input  wire  [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // tdata: slot[3:0], fired_action[11:4], fired_argument[43:12], zero pad
  output logic [teq_pkg::OUT_DATA_W-1:0]    out_tdata,
  // tuser: kind[2:0]
  output logic [2:0]                        out_tuser,
  output logic                              out_tlast
);

  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned HND_W  = (SLOT_W > 4) ? SLOT_W : 4;

  // input beat fields
  teq_pkg::cmd_e      in_cmd;
  logic [30:0]        in_interval;
  logic [7:0]         in_action;
  logic signed [31:0] in_argument;
  logic [3:0]         in_handle;
  logic [15:0]        in_elapsed;

  assign in_cmd      = teq_pkg::cmd_e'(in_tuser);
  assign in_interval = in_tdata[30:0];
  assign in_action   = in_tdata[38:31];
  assign in_argument = $signed(in_tdata[70:39]);
  assign in_handle   = in_tdata[74:71];
  assign in_elapsed  = in_tdata[90:75];

  teq_pkg::state_e    state_r, state_nxt;
  logic [31:0]        now_r;
  logic [DEPTH-1:0]   in_use_r, in_use_nxt;
  logic [31:0]        dl_r;
  logic               iv_zero_r;
  logic [7:0]         act_r;
  logic signed [31:0] arg_r;
  logic [HND_W-1:0]   hnd_r;
  teq_pkg::kind_e     kind_r;
  logic [3:0]         fin_slot_r;
  logic [DEPTH-1:0]   ge_r;
  logic [SLOT_W-1:0]  free_slot_r;
  logic               full_r;
  logic [teq_pkg::FIRE_W-1:0] fire_cnt_r;

  // output register
  logic               out_valid_r;
  teq_pkg::kind_e     out_kind_r;
  logic [3:0]         out_slot_r;
  logic [7:0]         out_act_r;
  logic signed [31:0] out_arg_r;
  logic               out_last_r;
  logic               out_space;

  // cell row
  teq_pkg::ctl_t      cell_ctl [DEPTH];
  teq_pkg::ent_t      ent_q    [DEPTH];
  logic [SLOT_W-1:0]  slot_q   [DEPTH];
  teq_pkg::flags_t    flags_q  [DEPTH];
  teq_pkg::ent_t      new_ent;
  teq_pkg::ent_t      tail_ent;
  logic [31:0]        cell_key;
  logic [DEPTH-1:0]   ge_vec, match_vec, valid_vec;

  // control from the sequencer
  logic               in_acc;
  logic               do_ins, do_rem, do_pop, emit;
  teq_pkg::kind_e     em_kind;
  logic [3:0]         em_slot;
  logic [7:0]         em_act;
  logic signed [31:0] em_arg;
  logic               em_last;

  // insert / remove position masks
  logic [DEPTH-1:0]   ins_first, ins_before, rem_before;
  logic               rem_hit, head_due;

  // lowest free slot
  logic [DEPTH-1:0]   free_vec, free_one;
  logic [SLOT_W-1:0]  free_idx;

  assign in_acc    = in_tvalid && in_tready;
  assign out_space = !out_valid_r || out_tready;

  assign new_ent.valid    = 1'b1;
  assign new_ent.deadline = dl_r;
  assign new_ent.action   = act_r;
  assign new_ent.argument = arg_r;

  assign tail_ent.valid    = 1'b0;
  assign tail_ent.deadline = 32'd0;
  assign tail_ent.action   = 8'd0;
  assign tail_ent.argument = 32'sd0;

  // cells compare against the new deadline during set, else against now
  assign cell_key = (state_r == teq_pkg::ST_SET) ? dl_r : now_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    teq_pkg::ent_t     prev_ent, next_ent;
    logic [SLOT_W-1:0] prev_slot, next_slot;

    if (i == 0) begin : g_first
      assign prev_ent  = new_ent;
      assign prev_slot = free_slot_r;
    end else begin : g_mid
      assign prev_ent  = ent_q[i-1];
      assign prev_slot = slot_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_ent  = tail_ent;
      assign next_slot = '0;
    end else begin : g_body
      assign next_ent  = ent_q[i+1];
      assign next_slot = slot_q[i+1];
    end

    teq_cell #(
      .SLOT_W (SLOT_W),
      .HND_W  (HND_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl_i       (cell_ctl[i]),
      .key_i       (cell_key),
      .hnd_i       (hnd_r),
      .new_ent_i   (new_ent),
      .new_slot_i  (free_slot_r),
      .prev_ent_i  (prev_ent),
      .prev_slot_i (prev_slot),
      .next_ent_i  (next_ent),
      .next_slot_i (next_slot),
      .ent_o       (ent_q[i]),
      .slot_o      (slot_q[i]),
      .flags_o     (flags_q[i])
    );

    assign ge_vec[i]    = flags_q[i].ge;
    assign match_vec[i] = flags_q[i].match;
    assign valid_vec[i] = ent_q[i].valid;
  end

  assign head_due = flags_q[0].due;

  // insert goes at the first cell whose entry is empty or not earlier;
  // cells below it hold, cells above it shift toward the tail
  assign ins_first  = ge_r & (~ge_r + DEPTH'(1));
  assign ins_before = ins_first - DEPTH'(1);

  // removal: the matching cell and all above it take from their successor
  assign rem_hit    = |match_vec;
  assign rem_before = match_vec - DEPTH'(1);

  // lowest free slot, one-hot then encoded
  assign free_vec = ~in_use_r;
  assign free_one = free_vec & (~free_vec + DEPTH'(1));

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (free_one[i]) begin
        free_idx = free_idx | SLOT_W'(i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    do_pop    = 1'b0;
    emit      = 1'b0;
    em_kind   = teq_pkg::K_TICK;
    em_slot   = 4'd0;
    em_act    = 8'd0;
    em_arg    = 32'sd0;
    em_last   = 1'b1;
    unique case (state_r)
      teq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_cmd)
            teq_pkg::CMD_SET:   state_nxt = teq_pkg::ST_SET;
            teq_pkg::CMD_CLEAR: state_nxt = teq_pkg::ST_CLR;
            teq_pkg::CMD_TICK:  state_nxt = teq_pkg::ST_FIRE;
            default:            state_nxt = teq_pkg::ST_IDLE;
          endcase
        end
      end
      teq_pkg::ST_SET: begin
        state_nxt = teq_pkg::ST_SET_WR;
      end
      teq_pkg::ST_SET_WR: begin
        if (out_space) begin
          emit      = 1'b1;
          state_nxt = teq_pkg::ST_IDLE;
          priority if (iv_zero_r) begin
            em_kind = teq_pkg::K_BAD_IVL;
          end else if (full_r) begin
            em_kind = teq_pkg::K_FULL;
          end else begin
            em_kind = teq_pkg::K_SET_OK;
            em_slot = 4'(free_slot_r);
            do_ins  = 1'b1;
          end
        end
      end
      teq_pkg::ST_CLR: begin
        do_rem    = rem_hit;
        state_nxt = teq_pkg::ST_FIRE;
      end
      teq_pkg::ST_FIRE: begin
        if (head_due && (fire_cnt_r < teq_pkg::FIRE_W'(teq_pkg::MAX_FIRE))) begin
          if (out_space) begin
            emit    = 1'b1;
            do_pop  = 1'b1;
            em_kind = teq_pkg::K_FIRED;
            em_slot = 4'(slot_q[0]);
            em_act  = ent_q[0].action;
            em_arg  = ent_q[0].argument;
            em_last = 1'b0;
          end
        end else if (out_space) begin
          emit      = 1'b1;
          em_kind   = kind_r;
          em_slot   = fin_slot_r;
          state_nxt = teq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = teq_pkg::ST_IDLE;
      end
    endcase
  end

  // per-cell shift control
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].op = teq_pkg::OP_HOLD;
      priority if (do_pop) begin
        cell_ctl[i].op = teq_pkg::OP_FROM_NEXT;
      end else if (do_ins) begin
        priority if (ins_before[i]) begin
          cell_ctl[i].op = teq_pkg::OP_HOLD;
        end else if (ins_first[i]) begin
          cell_ctl[i].op = teq_pkg::OP_LOAD;
        end else begin
          cell_ctl[i].op = teq_pkg::OP_FROM_PREV;
        end
      end else if (do_rem && !rem_before[i]) begin
        cell_ctl[i].op = teq_pkg::OP_FROM_NEXT;
      end else begin
        cell_ctl[i].op = teq_pkg::OP_HOLD;
      end
    end
  end

  // slot occupancy
  always_comb begin
    in_use_nxt = in_use_r;
    if (do_ins) begin
      in_use_nxt[free_slot_r] = 1'b1;
    end
    if (do_rem) begin
      in_use_nxt[hnd_r[SLOT_W-1:0]] = 1'b0;
    end
    if (do_pop) begin
      in_use_nxt[slot_q[0]] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= teq_pkg::ST_IDLE;
      now_r       <= 32'd0;
      in_use_r    <= '0;
      fire_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      in_use_r <= in_use_nxt;
      if (in_acc && (in_cmd == teq_pkg::CMD_TICK)) begin
        now_r <= now_r + 32'(in_elapsed);
      end
      if (in_acc) begin
        fire_cnt_r <= '0;
      end else if (do_pop) begin
        fire_cnt_r <= fire_cnt_r + teq_pkg::FIRE_W'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // command and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dl_r       <= now_r + {1'b0, in_interval};
      iv_zero_r  <= (in_interval == 31'd0);
      act_r      <= in_action;
      arg_r      <= in_argument;
      hnd_r      <= HND_W'(in_handle);
      kind_r     <= teq_pkg::K_TICK;
      fin_slot_r <= (in_cmd == teq_pkg::CMD_CLEAR) ? in_handle : 4'd0;
    end
    if (state_r == teq_pkg::ST_SET) begin
      ge_r        <= ge_vec;
      free_slot_r <= free_idx;
      full_r      <= ~|free_vec;
    end
    if (state_r == teq_pkg::ST_CLR) begin
      kind_r <= rem_hit ? teq_pkg::K_CLEARED : teq_pkg::K_NO_HND;
    end
    if (emit) begin
      out_kind_r <= em_kind;
      out_slot_r <= em_slot;
      out_act_r  <= em_act;
      out_arg_r  <= em_arg;
      out_last_r <= em_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(teq_pkg::OUT_DATA_W - 44){1'b0}}, out_arg_r, out_act_r, out_slot_r};

`ifndef NO_ASSERTIONS
  // occupied slots and occupied cells are equal in number
  a_use_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_use_r) == $countones(valid_vec))
    else $error("slot occupancy disagrees with cell row");

  // occupied cells form an unbroken run from the head
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, valid_vec} + (DEPTH + 1)'(1)))
    else $error("gap in cell row");

  // fire count never runs past the per-command cap
  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fire_cnt_r <= teq_pkg::FIRE_W'(teq_pkg::MAX_FIRE))
    else $error("fire count over cap");

  // a fired beat leaves the sequencer in the fire state, where the status beat follows
  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (em_kind == teq_pkg::K_FIRED)) |=> (state_r == teq_pkg::ST_FIRE))
    else $error("fired beat without trailing status");
`endif

endmodule

`default_nettype wire

/* tb/teq_tb_pkg.sv */
package teq_tb_pkg;
  import teq_pkg::*;

  localparam int unsigned SLOTS = DEPTH_DEF;

  // one result beat, as the checker sees it
  typedef struct packed {
    kind_e              kind;
    logic [3:0]         slot;
    logic [7:0]         action;
    logic signed [31:0] argument;
    logic               last;
  } teq_result_t;

  class timer_queue_scoreboard;
    // mirror of the queue: time counter, slots in deadline order, per-slot data
    logic [31:0]        now;
    logic [3:0]         order_q [SLOTS];
    int unsigned        queued;
    bit                 busy [SLOTS];
    logic [31:0]        deadline [SLOTS];
    logic [7:0]         act [SLOTS];
    logic signed [31:0] arg [SLOTS];

    teq_result_t pending_beats [$];

    int unsigned n_checked, n_errors, n_fired, n_full, n_bad, max_burst;
    bit          wrapped;

    function new();
      now       = '0;
      queued    = 0;
      wrapped   = 1'b0;
      n_checked = 0;
      n_errors  = 0;
      n_fired   = 0;
      n_full    = 0;
      n_bad     = 0;
      max_burst = 0;
      foreach (busy[i]) busy[i] = 1'b0;
    endfunction

    function void push_beat(kind_e kind, logic [3:0] slot, logic [7:0] action,
                            logic [31:0] argument, logic last);
      teq_result_t r;
      r.kind     = kind;
      r.slot     = slot;
      r.action   = action;
      r.argument = argument;
      r.last     = last;
      pending_beats.push_back(r);
    endfunction

    function void drop_at(int unsigned pos);
      for (int unsigned i = pos; i + 1 < queued; i++) order_q[i] = order_q[i + 1];
      queued--;
    endfunction

    // pop due events off the head, earliest first, capped per command
    function void fire_due();
      int unsigned n;
      logic [31:0] d;
      logic [3:0]  s;
      n = 0;
      while (n < MAX_FIRE && queued > 0) begin
        s = order_q[0];
        d = deadline[s] - now;
        if (d != '0 && !d[31]) break;
        push_beat(K_FIRED, s, act[s], arg[s], 1'b0);
        busy[s] = 1'b0;
        drop_at(0);
        n++;
      end
      n_fired += n;
      if (n > max_burst) max_burst = n;
    endfunction

    function void note_input(cmd_e cmd, logic [30:0] interval, logic [7:0] action,
                             logic [31:0] argument, logic [3:0] handle,
                             logic [15:0] elapsed);
      int unsigned s, pos;
      logic [31:0] due_at, d;
      kind_e       k;
      case (cmd)
        CMD_SET: begin
          if (interval == '0) begin
            push_beat(K_BAD_IVL, '0, '0, '0, 1'b1);
            n_bad++;
          end else begin
            for (s = 0; s < SLOTS; s++) if (!busy[s]) break;
            if (s >= SLOTS || queued >= SLOTS) begin
              push_beat(K_FULL, '0, '0, '0, 1'b1);
              n_full++;
            end else begin
              due_at = now + {1'b0, interval};
              // new event goes ahead of the first equal-or-later deadline
              for (pos = 0; pos < queued; pos++) begin
                d = deadline[order_q[pos]] - due_at;
                if (!d[31]) break;
              end
              for (int unsigned i = queued; i > pos; i--) order_q[i] = order_q[i - 1];
              order_q[pos] = s[3:0];
              queued++;
              busy[s]     = 1'b1;
              deadline[s] = due_at;
              act[s]      = action;
              arg[s]      = argument;
              push_beat(K_SET_OK, s[3:0], '0, '0, 1'b1);
            end
          end
        end
        CMD_CLEAR: begin
          k = K_NO_HND;
          if (busy[handle]) begin
            for (pos = 0; pos < queued; pos++) if (order_q[pos] == handle) break;
            if (pos < queued) drop_at(pos);
            busy[handle] = 1'b0;
            k = K_CLEARED;
          end
          fire_due();
          push_beat(k, handle, '0, '0, 1'b1);
        end
        CMD_TICK: begin
          due_at = now + {16'h0, elapsed};
          if (due_at < now) wrapped = 1'b1;
          now = due_at;
          fire_due();
          push_beat(K_TICK, '0, '0, '0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(teq_result_t got);
      teq_result_t want;
      n_checked++;
      if (pending_beats.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: result beat with nothing pending: kind=%0d slot=%0d act=%02h arg=%08h last=%0b",
                   got.kind, got.slot, got.action, got.argument, got.last);
        return;
      end
      want = pending_beats.pop_front();
      if (got.kind !== want.kind || got.slot !== want.slot || got.action !== want.action ||
          got.argument !== want.argument || got.last !== want.last) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("ERROR: result beat %0d: expected kind=%0d slot=%0d act=%02h arg=%08h last=%0b",
                   n_checked, want.kind, want.slot, want.action, want.argument, want.last);
          $display("       got                  kind=%0d slot=%0d act=%02h arg=%08h last=%0b",
                   got.kind, got.slot, got.action, got.argument, got.last);
        end
      end
    endfunction
  endclass

endpackage

/* tb/tb_timed_event_queue.sv */
module tb_timed_event_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import teq_pkg::*;
  import teq_tb_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned IDLE_PCT     = 11;
  localparam int unsigned HOLD_CYCLES  = 400;        // long output stall, holds the block back
  localparam int unsigned DRAIN_CYCLES = 40;         // covers a 17-beat answer

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  out_tlast;

  bit          steady  = 1'b0;  // both sides stop idling while set
  bit          hold_go = 1'b0;  // kicks off the long receiver stall
  bit          hold_off = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned n_items = 0;     // command beats accepted, ignored ones excluded
  teq_result_t seen_beat;

  timer_queue_scoreboard timer_sb = new();

  always #(CLK_PERIOD / 2) clk = ~clk;

  timed_event_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Drive one command beat and hold it until the block takes it. Idle cycles
  // go in front of the beat, so valid never drops while a beat is pending.
  // Handshake is sampled right after the edge, i.e. pre-edge values.
  task automatic offer_beat(cmd_e cmd, logic [30:0] interval, logic [7:0] action,
                            logic [31:0] argument, logic [3:0] handle,
                            logic [15:0] elapsed);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    // tdata: interval, action, argument, handle, elapsed from bit 0 up
    in_tdata  <= {5'b0, elapsed, handle, argument, action, interval};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    timer_sb.note_input(cmd, interval, action, argument, handle, elapsed);
    if (cmd != CMD_NONE) n_items++;
  endtask

  // Extremes, both answers of an empty queue, a full queue whose equal
  // deadlines fire newest first as one 17-beat answer, a double clear.
  task automatic directed_part();
    logic [31:0] a;
    offer_beat(CMD_SET, '0, 8'hFF, 32'h8000_0000, 4'hF, 16'hFFFF);  // zero interval
    offer_beat(CMD_NONE, '1, '1, '1, '1, '1);                        // dropped silently
    offer_beat(CMD_CLEAR, '0, '0, '0, 4'hF, '0);                     // handle not queued
    offer_beat(CMD_TICK, '1, '1, '1, '1, 16'h0);                     // zero elapsed
    for (int i = 0; i < SLOTS; i++) begin
      a = (i == 0) ? 32'h8000_0000 : (i == 1) ? 32'h7FFF_FFFF : (i == 2) ? '1 : $urandom;
      offer_beat(CMD_SET, 31'd5, 8'(i * 17), a, 4'($urandom), 16'($urandom));
    end
    offer_beat(CMD_SET, 31'd9, 8'h5A, 32'h1234_5678, '0, '0);        // queue full
    offer_beat(CMD_TICK, '0, '0, '0, '0, 16'd5);                     // all 16 fire
    offer_beat(CMD_SET, 31'h7FFF_FFFF, 8'h00, 32'h0, '0, '0);        // farthest deadline
    offer_beat(CMD_CLEAR, '0, '0, '0, 4'd0, '0);
    offer_beat(CMD_CLEAR, '0, '0, '0, 4'd0, '0);                     // already gone
    offer_beat(CMD_TICK, '0, '0, '0, '0, 16'hFFFF);
  endtask

  // Mostly well-formed traffic: sets with short deadlines that later ticks
  // fire, clears of live handles, plus zero intervals, far deadlines, stray
  // handles, ignored commands and the odd fill-to-full burst.
  task automatic random_phase(int unsigned count, int unsigned calm_from,
                              int unsigned calm_to);
    int unsigned done, pick, r;
    int unsigned live [$];
    logic [30:0] ivl;
    logic [15:0] el;
    logic [3:0]  h;
    done = 0;
    while (done < count) begin
      steady <= (done >= calm_from && done < calm_to);
      pick = $urandom_range(99);
      r    = $urandom_range(99);
      if (pick < 3) begin
        while (timer_sb.queued < SLOTS) begin
          offer_beat(CMD_SET, 31'($urandom_range(1, 400)), 8'($urandom), $urandom,
                     4'($urandom), 16'($urandom));
          done++;
        end
        offer_beat(CMD_SET, 31'($urandom_range(1, 400)), 8'($urandom), $urandom,
                   4'($urandom), 16'($urandom));
        offer_beat(CMD_TICK, 31'($urandom), 8'($urandom), $urandom, 4'($urandom), 16'd400);
        done += 2;
      end else if (pick < 48) begin
        ivl = (r < 8) ? '0 : (r < 25) ? 31'($urandom) : 31'($urandom_range(1, 3000));
        offer_beat(CMD_SET, ivl, 8'($urandom), $urandom, 4'($urandom), 16'($urandom));
        done++;
      end else if (pick < 66) begin
        live.delete();
        foreach (timer_sb.busy[i]) if (timer_sb.busy[i]) live.push_back(i);
        h = (live.size() != 0 && r < 75) ? 4'(live[$urandom_range(live.size() - 1)])
                                          : 4'($urandom);
        offer_beat(CMD_CLEAR, 31'($urandom), 8'($urandom), $urandom, h, 16'($urandom));
        done++;
      end else if (pick < 94) begin
        el = (r < 70) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
        offer_beat(CMD_TICK, 31'($urandom), 8'($urandom), $urandom, 4'($urandom), el);
        done++;
      end else begin
        offer_beat(CMD_NONE, 31'($urandom), 8'($urandom), $urandom, 4'($urandom),
                   16'($urandom));
      end
    end
  endtask

  // Receiver: check every accepted result beat, then pick next ready.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_beat.kind     = kind_e'(out_tuser);
      seen_beat.slot     = out_tdata[3:0];
      seen_beat.action   = out_tdata[11:4];
      seen_beat.argument = out_tdata[43:12];
      seen_beat.last     = out_tlast;
      timer_sb.check_result(seen_beat);
    end
    out_tready <= !hold_off && (steady || $urandom_range(99) >= IDLE_PCT);
  end

  // One long stall of the receiver, counted here while the sender keeps going.
  initial begin
    wait (hold_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: no end after %0d cycles, %0d result beats still pending",
               cycle_count, timer_sb.pending_beats.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_part();

    // first random stretch starts under the long output stall
    hold_go <= 1'b1;
    random_phase(200, 110, 190);

    random_phase(240, 0, 0);
    in_tvalid <= 1'b0;

    while (timer_sb.pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d command beats and %0d result beats: %0d events fired (up to %0d at once),",
             n_items, timer_sb.n_checked, timer_sb.n_fired, timer_sb.max_burst);
    $display("%0d full and %0d zero-interval answers; time counter wrapped: %s",
             timer_sb.n_full, timer_sb.n_bad, timer_sb.wrapped ? "yes" : "no");
    if (timer_sb.n_errors > 10)
      $display("ERROR: %0d mismatches in total", timer_sb.n_errors);
    if (timer_sb.pending_beats.size() != 0)
      $display("ERROR: %0d expected result beats never arrived",
               timer_sb.pending_beats.size());

    if (timer_sb.n_errors == 0 && timer_sb.pending_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
